FILE: design/gfn_pkg.sv
`default_nettype none

package gfn_pkg;

  // Gradient table geometry: the grid is a power of two on each axis.
  localparam int GRID_LOG2   = 5;
  localparam int TAB_AW      = 2 * GRID_LOG2;
  localparam int TAB_ENTRIES = 1 << TAB_AW;

  // Field widths.
  localparam int GRAD_W     = 16;
  localparam int TAB_DW     = 2 * GRAD_W;
  localparam int COORD_W    = 32;
  localparam int FREQ_W     = 24;
  localparam int PERS_W     = 16;
  localparam int OCT_W      = 4;
  localparam int CNT_W      = OCT_W + 1;
  localparam int NOISE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Fixed-point formats.
  localparam int COORD_FRAC_BITS = 16;
  localparam int FREQ_FRAC_BITS  = 16;
  localparam int FRAC_W          = 16;
  localparam int FADE_W          = FRAC_W + 1;
  localparam int ONE_Q16         = 1 << FRAC_W;
  localparam int AMP_W           = FRAC_W + 1;

  // Scaled position, corner dot products and the weighted accumulator.
  localparam int POS_W  = COORD_W + FREQ_W + 1;
  localparam int DOT_W  = GRAD_W + FRAC_W + 2;
  localparam int ACC_W  = DOT_W + AMP_W + 1 + 4;
  localparam int NORM_W = AMP_W + 4;

  // Quintic fade coefficients: 6t^5 - 15t^4 + 10t^3.
  localparam int FADE_C5 = 6;
  localparam int FADE_C4 = 15;
  localparam int FADE_C3 = 10;

  // Divider: one quotient bit per stage plus an overflow check.
  localparam int QUO_BITS = NOISE_W - 1;
  localparam int DIV_LAT  = QUO_BITS + 2;

  localparam int DEF_MAX_OCTAVES = 8;

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = {1'b0, {(NOISE_W-1){1'b1}}};
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = {1'b1, {(NOISE_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCTAVES   = 2'd0,
    CFG_PERSIST   = 2'd1,
    CFG_BASE_FREQ = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  // Write port of the gradient tables.
  typedef struct packed {
    logic              en;
    logic [TAB_AW-1:0] addr;
    logic [TAB_DW-1:0] data;
  } tab_wr_t;

endpackage

`default_nettype wire

FILE: design/gfn_table.sv
`default_nettype none

module gfn_table (
  input  wire logic                  clk_i,
  input  wire gfn_pkg::tab_wr_t      wr_i,
  input  wire logic                  re_i,
  input  wire logic [gfn_pkg::TAB_AW-1:0] raddr0_i,
  input  wire logic [gfn_pkg::TAB_AW-1:0] raddr1_i,
  output logic [gfn_pkg::TAB_DW-1:0] rdata0_o,
  output logic [gfn_pkg::TAB_DW-1:0] rdata1_o
);
  import gfn_pkg::*;

  logic [TAB_DW-1:0] mem [TAB_ENTRIES];
  logic [TAB_DW-1:0] rd0_q, rd1_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (re_i) begin
      rd0_q <= mem[raddr0_i];
      rd1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule

`default_nettype wire

FILE: design/gfn_octave.sv
`default_nettype none

module gfn_octave #(
  parameter int OCT = 0
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic signed [gfn_pkg::POS_W-1:0] px_i,
  input  wire logic signed [gfn_pkg::POS_W-1:0] py_i,
  input  wire gfn_pkg::tab_wr_t                 wr_i,
  output logic signed [gfn_pkg::DOT_W-1:0]      val_o
);
  import gfn_pkg::*;

  localparam int SHIFT  = COORD_FRAC_BITS + FREQ_FRAC_BITS - OCT;
  localparam int EXT_W  = POS_W + FRAC_W;
  localparam int QA_W   = 38;
  localparam int Q_W    = 20;
  localparam int DIFF_W = DOT_W + 1;
  localparam int PROD_W = DIFF_W + FADE_W + 1;

  // Corner dot product: gradient times offset, exact.
  function automatic logic signed [DOT_W-1:0] dot_f(
    input logic [TAB_DW-1:0]       g,
    input logic signed [FRAC_W:0]  ox,
    input logic signed [FRAC_W:0]  oy
  );
    logic signed [GRAD_W-1:0]        gx, gy;
    logic signed [GRAD_W+FRAC_W:0]   mx, my;
    gx = g[TAB_DW-1:GRAD_W];
    gy = g[GRAD_W-1:0];
    mx = gx * ox;
    my = gy * oy;
    return DOT_W'(mx) + DOT_W'(my);
  endfunction

  // Linear blend a + floor((b - a) * f / 2^16).
  function automatic logic signed [DOT_W-1:0] blend_f(
    input logic signed [DOT_W-1:0] a,
    input logic signed [DOT_W-1:0] b,
    input logic [FADE_W-1:0]       f
  );
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    diff = DIFF_W'(b) - DIFF_W'(a);
    prod = diff * $signed({1'b0, f});
    return a + DOT_W'(prod >>> FRAC_W);
  endfunction

  // Middle term of the fade, floor((10*2^32 - 15*2^16*t + 6*t^2) / 2^16).
  function automatic logic [Q_W-1:0] fade_q_f(
    input logic [FRAC_W-1:0]   t,
    input logic [2*FRAC_W-1:0] tt
  );
    logic [QA_W-1:0] qa;
    qa = (QA_W'(FADE_C3) << (2 * FRAC_W)) + QA_W'(tt) * QA_W'(FADE_C5)
       - ((QA_W'(t) * QA_W'(FADE_C4)) << FRAC_W);
    return qa[FRAC_W +: Q_W];
  endfunction

  // Last fade step, floor(t3 * q / 2^16) capped at one.
  function automatic logic [FADE_W-1:0] fade_f(
    input logic [FRAC_W-1:0] t3,
    input logic [Q_W-1:0]    q
  );
    logic [FRAC_W+Q_W-1:0] p;
    logic [Q_W-1:0]        r;
    p = t3 * q;
    r = p[FRAC_W +: Q_W];
    return (r > Q_W'(ONE_Q16)) ? FADE_W'(ONE_Q16) : r[FADE_W-1:0];
  endfunction

  // Cell and fraction are plain bit fields of the scaled position.
  logic [EXT_W-1:0]     ext_x, ext_y;
  logic [GRID_LOG2-1:0] x0, x1, y0, y1;
  logic [FRAC_W-1:0]    tx, ty;

  assign ext_x = {px_i, {FRAC_W{1'b0}}};
  assign ext_y = {py_i, {FRAC_W{1'b0}}};
  assign x0    = ext_x[SHIFT + FRAC_W +: GRID_LOG2];
  assign y0    = ext_y[SHIFT + FRAC_W +: GRID_LOG2];
  assign x1    = x0 + GRID_LOG2'(1);
  assign y1    = y0 + GRID_LOG2'(1);
  assign tx    = ext_x[SHIFT +: FRAC_W];
  assign ty    = ext_y[SHIFT +: FRAC_W];

  // Two table copies serve the four corners.
  logic [TAB_DW-1:0] g00, g10, g01, g11;

  gfn_table u_tab_lo (
    .clk_i    (clk_i),
    .wr_i     (wr_i),
    .re_i     (en_i),
    .raddr0_i ({x0, y0}),
    .raddr1_i ({x1, y0}),
    .rdata0_o (g00),
    .rdata1_o (g10)
  );

  gfn_table u_tab_hi (
    .clk_i    (clk_i),
    .wr_i     (wr_i),
    .re_i     (en_i),
    .raddr0_i ({x0, y1}),
    .raddr1_i ({x1, y1}),
    .rdata0_o (g01),
    .rdata1_o (g11)
  );

  // Stage 3: fractions line up with the table read data.
  logic [FRAC_W-1:0] tx3_q, ty3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx3_q <= tx;
      ty3_q <= ty;
    end
  end

  // Stage 4: corner dot products and squared fractions.
  logic signed [FRAC_W:0]    ox0, ox1, oy0, oy1;
  logic signed [DOT_W-1:0]   d00_4_q, d10_4_q, d01_4_q, d11_4_q;
  logic [2*FRAC_W-1:0]       ttx4_q, tty4_q;
  logic [FRAC_W-1:0]         tx4_q, ty4_q;

  assign ox0 = {1'b0, tx3_q};
  assign ox1 = {1'b1, tx3_q};
  assign oy0 = {1'b0, ty3_q};
  assign oy1 = {1'b1, ty3_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d00_4_q <= dot_f(g00, ox0, oy0);
      d10_4_q <= dot_f(g10, ox1, oy0);
      d01_4_q <= dot_f(g01, ox0, oy1);
      d11_4_q <= dot_f(g11, ox1, oy1);
      ttx4_q  <= tx3_q * tx3_q;
      tty4_q  <= ty3_q * ty3_q;
      tx4_q   <= tx3_q;
      ty4_q   <= ty3_q;
    end
  end

  // Stage 5: cube of the fraction and the middle fade term.
  logic [3*FRAC_W-1:0]     cubx, cuby;
  logic [FRAC_W-1:0]       t3x5_q, t3y5_q;
  logic [Q_W-1:0]          qx5_q, qy5_q;
  logic signed [DOT_W-1:0] d00_5_q, d10_5_q, d01_5_q, d11_5_q;

  assign cubx = ttx4_q * tx4_q;
  assign cuby = tty4_q * ty4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3x5_q  <= cubx[2*FRAC_W +: FRAC_W];
      t3y5_q  <= cuby[2*FRAC_W +: FRAC_W];
      qx5_q   <= fade_q_f(tx4_q, ttx4_q);
      qy5_q   <= fade_q_f(ty4_q, tty4_q);
      d00_5_q <= d00_4_q;
      d10_5_q <= d10_4_q;
      d01_5_q <= d01_4_q;
      d11_5_q <= d11_4_q;
    end
  end

  // Stage 6: fade weights.
  logic [FADE_W-1:0]       fx6_q, fy6_q;
  logic signed [DOT_W-1:0] d00_6_q, d10_6_q, d01_6_q, d11_6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx6_q   <= fade_f(t3x5_q, qx5_q);
      fy6_q   <= fade_f(t3y5_q, qy5_q);
      d00_6_q <= d00_5_q;
      d10_6_q <= d10_5_q;
      d01_6_q <= d01_5_q;
      d11_6_q <= d11_5_q;
    end
  end

  // Stage 7: blend along x.
  logic signed [DOT_W-1:0] top7_q, bot7_q;
  logic [FADE_W-1:0]       fy7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      top7_q <= blend_f(d00_6_q, d10_6_q, fx6_q);
      bot7_q <= blend_f(d01_6_q, d11_6_q, fx6_q);
      fy7_q  <= fy6_q;
    end
  end

  // Stage 8: blend along y gives the octave value.
  logic signed [DOT_W-1:0] val8_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val8_q <= blend_f(top7_q, bot7_q, fy7_q);
    end
  end

  assign val_o = val8_q;

endmodule

`default_nettype wire

FILE: design/gfn_div.sv
`default_nettype none

module gfn_div (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic signed [gfn_pkg::ACC_W-1:0] total_i,
  input  wire logic [gfn_pkg::NORM_W-1:0]       norm_i,
  output logic signed [gfn_pkg::NOISE_W-1:0]    noise_o
);
  import gfn_pkg::*;

  localparam int STEPS = QUO_BITS + 1;

  logic [ACC_W-1:0]    rem_q [0:STEPS];
  logic                neg_q [0:STEPS];
  logic                sat_q [1:STEPS];
  logic [QUO_BITS-1:0] quo_q [1:STEPS];

  // Stage 0: split the sum into sign and magnitude.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= total_i < 0;
      rem_q[0] <= (total_i < 0) ? ACC_W'(-total_i) : ACC_W'(total_i);
    end
  end

  // Restoring division by norm * 2^15, one quotient bit per stage. The first
  // step only checks whether the quotient overflows the output range.
  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int K = STEPS - j;
    logic [ACC_W-1:0] dk;
    logic             ge;

    assign dk = ACC_W'(norm_i) << (QUO_BITS + K);
    assign ge = rem_q[j-1] >= dk;

    if (j == 1) begin : g_ovf
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sat_q[j] <= ge;
          rem_q[j] <= rem_q[j-1];
          quo_q[j] <= '0;
          neg_q[j] <= neg_q[j-1];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sat_q[j] <= sat_q[j-1];
          rem_q[j] <= ge ? rem_q[j-1] - dk : rem_q[j-1];
          quo_q[j] <= quo_q[j-1] | (QUO_BITS'(ge) << K);
          neg_q[j] <= neg_q[j-1];
        end
      end
    end
  end

  // Apply the sign and saturate.
  always_comb begin
    if (sat_q[STEPS]) begin
      noise_o = neg_q[STEPS] ? NOISE_MIN : NOISE_MAX;
    end else if (neg_q[STEPS]) begin
      noise_o = -$signed({1'b0, quo_q[STEPS]});
    end else begin
      noise_o = $signed({1'b0, quo_q[STEPS]});
    end
  end

endmodule

`default_nettype wire

FILE: design/fractal_gradient_noise_2d.sv
`default_nettype none

// Fractal 2D gradient noise, fully pipelined.
// Input channel: one transaction per cycle when in_valid_i is high and
// in_stall_o is low. A load (opcode 0) writes one gradient table entry and
// gives no output; an evaluate (opcode 1) gives one noise_value_o on the
// output channel, in order, taken when out_valid_o is high and out_stall_i
// is low. Throughput is one transaction per cycle while in_stall_o is low.
// Results pass through the input and scaling registers, the octave lanes,
// the adder tree, a 17-stage restoring divider and the output register.
// Each octave lane holds two copies of the gradient table; loads write all
// copies once they reach stage 2, in order with the evaluates.
// When the output register is full and stalled, the whole pipeline holds and
// in_stall_o rises; nothing is lost or repeated.
// Configuration writes (cfg_ready_o is always high) recompute the octave
// amplitudes and their sum; input is stalled after each write while they
// settle.
// Reset empties the pipeline and restores the default registers; the
// gradient table is not cleared and must be loaded before it is read.
module fractal_gradient_noise_2d #(
  parameter int MAX_OCTAVES = gfn_pkg::DEF_MAX_OCTAVES
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input channel.
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 opcode_i,
  input  wire logic signed [gfn_pkg::COORD_W-1:0]   x_coord_i,
  input  wire logic signed [gfn_pkg::COORD_W-1:0]   y_coord_i,
  input  wire logic [gfn_pkg::TAB_AW-1:0]           grad_index_i,
  input  wire logic signed [gfn_pkg::GRAD_W-1:0]    grad_x_i,
  input  wire logic signed [gfn_pkg::GRAD_W-1:0]    grad_y_i,
  // Output channel.
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [gfn_pkg::NOISE_W-1:0]        noise_value_o,
  // Configuration channel.
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [gfn_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [gfn_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import gfn_pkg::*;

  localparam int LVL      = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 0;
  localparam int LEAVES   = 1 << LVL;
  localparam int LANE_LAT = 6;
  localparam int N_STG    = 2 + LANE_LAT + 1 + LVL + DIV_LAT;
  localparam int SETTLE   = MAX_OCTAVES + 1;
  localparam int SET_W    = $clog2(SETTLE + 1);

  logic pipe_en;
  logic in_acc;
  logic cfg_acc;
  logic busy;

  // Configuration registers.
  logic [OCT_W-1:0]  oct_q;
  logic [PERS_W-1:0] pers_q;
  logic [FREQ_W-1:0] bf_q;
  logic [SET_W-1:0]  settle_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_q    <= OCT_W'(1);
      pers_q   <= PERS_W'(ONE_Q16 >> 1);
      bf_q     <= FREQ_W'(ONE_Q16);
      settle_q <= '0;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        CFG_OCTAVES:   oct_q  <= cfg_data_i[OCT_W-1:0];
        CFG_PERSIST:   pers_q <= cfg_data_i[PERS_W-1:0];
        CFG_BASE_FREQ: bf_q   <= cfg_data_i[FREQ_W-1:0];
        default:       ;
      endcase
      settle_q <= SET_W'(SETTLE);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - SET_W'(1);
    end
  end

  assign busy = settle_q != '0;

  // Effective octave count, clamped to 1..MAX_OCTAVES.
  logic [CNT_W-1:0] n_eff;

  always_comb begin
    if (oct_q == '0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, oct_q} > CNT_W'(MAX_OCTAVES)) begin
      n_eff = CNT_W'(MAX_OCTAVES);
    end else begin
      n_eff = {1'b0, oct_q};
    end
  end

  // Octave amplitudes: a chain of registered products of the persistence.
  logic [AMP_W-1:0] amp_q [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_amp
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          amp_q[i] <= AMP_W'(ONE_Q16);
        end else begin
          amp_q[i] <= AMP_W'(ONE_Q16);
        end
      end
    end else begin : g_next
      logic [AMP_W+PERS_W-1:0] ap;
      assign ap = amp_q[i-1] * pers_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          amp_q[i] <= AMP_W'(ONE_Q16 >> i);
        end else begin
          amp_q[i] <= AMP_W'(ap >> PERS_W);
        end
      end
    end
  end

  // Sum of the amplitudes of the active octaves.
  logic [NORM_W-1:0] norm_d, norm_q;

  always_comb begin
    norm_d = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (CNT_W'(i) < n_eff) begin
        norm_d = norm_d + NORM_W'(amp_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= NORM_W'(ONE_Q16);
    end else begin
      norm_q <= norm_d;
    end
  end

  // Handshake: the pipeline moves unless a finished result is stalled.
  logic out_valid_q;

  assign pipe_en    = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~pipe_en | busy;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Valid bits of evaluate transactions and of loads.
  logic [N_STG:1] ev_q;
  logic           ld1_q, ld2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q  <= '0;
      ld1_q <= 1'b0;
      ld2_q <= 1'b0;
    end else if (pipe_en) begin
      ev_q  <= {ev_q[N_STG-1:1], in_acc & (opcode_i == OP_EVAL)};
      ld1_q <= in_acc & (opcode_i == OP_LOAD);
      ld2_q <= ld1_q;
    end
  end

  // Stage 1: input registers.
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [TAB_AW-1:0]         gidx1_q;
  logic [TAB_DW-1:0]         gxy1_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x_q     <= x_coord_i;
      y_q     <= y_coord_i;
      gidx1_q <= grad_index_i;
      gxy1_q  <= {grad_x_i, grad_y_i};
    end
  end

  // Stage 2: scale the point by the base frequency.
  logic signed [POS_W-1:0] px_d, py_d, px_q, py_q;
  logic [TAB_AW-1:0]       gidx2_q;
  logic [TAB_DW-1:0]       gxy2_q;

  assign px_d = x_q * $signed({1'b0, bf_q});
  assign py_d = y_q * $signed({1'b0, bf_q});

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      px_q    <= px_d;
      py_q    <= py_d;
      gidx2_q <= gidx1_q;
      gxy2_q  <= gxy1_q;
    end
  end

  // Loads write every table copy at the read stage, keeping order.
  tab_wr_t tab_wr;

  assign tab_wr.en   = ld2_q & pipe_en;
  assign tab_wr.addr = gidx2_q;
  assign tab_wr.data = gxy2_q;

  // Octave lanes.
  logic signed [DOT_W-1:0] oct_val [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    gfn_octave #(
      .OCT (i)
    ) u_oct (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .px_i  (px_q),
      .py_i  (py_q),
      .wr_i  (tab_wr),
      .val_o (oct_val[i])
    );
  end

  // Weighting by amplitude, then a registered adder tree.
  logic signed [ACC_W-1:0] tr_q [0:LVL][0:LEAVES-1];

  for (genvar k = 0; k < LEAVES; k++) begin : g_w
    if (k < MAX_OCTAVES) begin : g_act
      logic signed [DOT_W+AMP_W:0] wprod;
      assign wprod = oct_val[k] * $signed({1'b0, amp_q[k]});
      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          tr_q[0][k] <= (CNT_W'(k) < n_eff) ? ACC_W'(wprod) : '0;
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          tr_q[0][k] <= '0;
        end
      end
    end
  end

  for (genvar l = 1; l <= LVL; l++) begin : g_lvl
    for (genvar k = 0; k < (LEAVES >> l); k++) begin : g_node
      always_ff @(posedge clk_i) begin
        if (pipe_en) begin
          tr_q[l][k] <= tr_q[l-1][2*k] + tr_q[l-1][2*k+1];
        end
      end
    end
  end

  // Normalize by the amplitude sum.
  logic signed [NOISE_W-1:0] div_noise;

  gfn_div u_div (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .total_i (tr_q[LVL][0]),
    .norm_i  (norm_q),
    .noise_o (div_noise)
  );

  // Output register.
  logic signed [NOISE_W-1:0] noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= ev_q[N_STG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      noise_q <= div_noise;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule

`default_nettype wire
